// File: src/ack_retransmit_table_macros.svh
// Assertion macros for the retransmission table checker.
`ifndef ACK_RETRANSMIT_TABLE_MACROS_SVH
`define ACK_RETRANSMIT_TABLE_MACROS_SVH

// Checks that a property holds on every clock edge outside reset.
`define ART_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that a condition is followed by an expectation in the next cycle.
`define ART_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> conseq) \
    else $error(msg);

`endif

// File: src/art_pkg.sv
// Package with the types and codes of the acknowledgement retransmission table.
`default_nettype none

package art_pkg;

  localparam int TIMEOUT_W = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_CONFIRM = 3'd1,
    FUNC_TICK    = 3'd2,
    FUNC_AUTH    = 3'd3,
    FUNC_DISC    = 3'd4
  } func_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_DUP       = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_CONFIRMED = 3'd3,
    KIND_NOT_FOUND = 3'd4,
    KIND_RESEND    = 3'd5,
    KIND_DONE      = 3'd6,
    KIND_ACK       = 3'd7
  } kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  // One input item.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  plugin;
    logic [7:0]  command;
    logic [31:0] business_id;
    logic [31:0] crc;
    logic [15:0] payload_tag;
    logic [31:0] now_secs;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  plugin_out;
    logic [7:0]  command_out;
    logic [31:0] business_out;
    logic [15:0] payload_out;
    logic        last;
  } out_item_t;

  // One stored table entry.
  typedef struct packed {
    logic [7:0]  plugin;
    logic [7:0]  command;
    logic [31:0] crc;
    logic [31:0] business;
    logic [15:0] payload;
    logic [31:0] sent_time;
  } entry_t;

endpackage

`default_nettype wire

// File: src/ack_retransmit_table.sv
// Top level of the acknowledgement retransmission table.
//
// The table holds up to DEPTH sent packets, in order, in one synchronous memory
// with a registered read. Every add, confirm and tick walks the held entries one
// per cycle through that memory port, while no resend waits for the output
// register. A confirm that matches spends the rest of its walk moving the later
// entries down one per cycle, and an add that finds a duplicate stops its walk at
// that entry. Authorize and disconnect do not walk the table. A result that waits
// for the output register delays the end of the item. Items are handled one at a
// time: in_stall is high from the transfer of an item until its last result is
// loaded into the output register, and a result waiting there does not hold off
// the next input transfer. A tick emits one resend result per expired entry and
// then a scan-done result marked last. The table needs no clearing after reset.
`default_nettype none

module ack_retransmit_table #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  art_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output art_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [art_pkg::TIMEOUT_W-1:0]      cfg_data
);
  import art_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  state_t               state_r, state_nxt;
  in_item_t             item_r, item_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 auth_r, auth_nxt;
  logic [TIMEOUT_W-1:0] timeout_r;
  out_item_t            fin_r, fin_nxt;
  out_item_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  entry_t               entry_mem [DEPTH];
  entry_t               rd_data_r;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  entry_t               wr_data;

  logic [CW:0]          idx_p1;
  logic [CW:0]          idx_p2;
  logic                 out_free;
  logic                 key_hit;
  logic                 bus_hit;
  logic [31:0]          age;
  logic                 expired;
  entry_t               new_entry;
  entry_t               stamped;

  // Builds a result that carries the fields of a stored entry.
  function automatic out_item_t entry_result(input kind_t kind, input entry_t e);
    out_item_t r;
    r.kind         = kind;
    r.plugin_out   = e.plugin;
    r.command_out  = e.command;
    r.business_out = e.business;
    r.payload_out  = e.payload;
    r.last         = 1'b0;
    return r;
  endfunction

  // Builds a result with all entry fields zero.
  function automatic out_item_t plain_result(input kind_t kind);
    out_item_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  // Compare and age logic on the entry read last cycle.
  assign idx_p1   = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx_r} + (CW+1)'(2);
  assign out_free = !out_valid_r || !out_stall;
  assign key_hit  = (rd_data_r.plugin == item_r.plugin) &&
                    (rd_data_r.command == item_r.command) &&
                    (rd_data_r.crc == item_r.crc);
  assign bus_hit  = (rd_data_r.business == item_r.business_id);
  assign age      = item_r.now_secs - rd_data_r.sent_time;
  assign expired  = auth_r && (age > {16'b0, timeout_r});

  // Entry images for an append and for a restamp.
  always_comb begin
    new_entry.plugin    = item_r.plugin;
    new_entry.command   = item_r.command;
    new_entry.crc       = item_r.crc;
    new_entry.business  = item_r.business_id;
    new_entry.payload   = item_r.payload_tag;
    new_entry.sent_time = item_r.now_secs;
    stamped             = rd_data_r;
    stamped.sent_time   = item_r.now_secs;
  end

  // Next state, memory access and result loading.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    auth_nxt      = auth_r;
    fin_nxt       = fin_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = idx_p1[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_data       = rd_data_r;
    in_stall      = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        // Entry 0 is read ahead so that a scan starts on it.
        rd_addr = '0;
        idx_nxt = '0;
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.func)
            FUNC_ADD, FUNC_CONFIRM, FUNC_TICK: begin
              state_nxt = S_SCAN;
            end
            FUNC_AUTH: begin
              auth_nxt  = 1'b1;
              fin_nxt   = plain_result(KIND_ACK);
              state_nxt = S_FIN;
            end
            FUNC_DISC: begin
              auth_nxt  = 1'b0;
              fin_nxt   = plain_result(KIND_ACK);
              state_nxt = S_FIN;
            end
            default: begin
              // Unknown codes are dropped without a result.
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (idx_r == count_r) begin
          // The walk passed the last held entry.
          case (item_r.func)
            FUNC_ADD: begin
              if (count_r == FULL_COUNT) begin
                fin_nxt = plain_result(KIND_FULL);
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = new_entry;
                count_nxt = count_r + CW'(1);
                fin_nxt   = plain_result(KIND_ADDED);
              end
            end
            FUNC_CONFIRM: begin
              fin_nxt = plain_result(KIND_NOT_FOUND);
            end
            default: begin
              fin_nxt = plain_result(KIND_DONE);
            end
          endcase
          state_nxt = S_FIN;
        end else begin
          case (item_r.func)
            FUNC_ADD: begin
              if (key_hit) begin
                fin_nxt   = plain_result(KIND_DUP);
                state_nxt = S_FIN;
              end else begin
                idx_nxt = idx_p1[CW-1:0];
              end
            end
            FUNC_CONFIRM: begin
              if (key_hit && bus_hit) begin
                // Entry idx+1 is read next for the move down.
                fin_nxt   = entry_result(KIND_CONFIRMED, rd_data_r);
                state_nxt = S_SHIFT;
              end else begin
                idx_nxt = idx_p1[CW-1:0];
              end
            end
            default: begin
              if (expired) begin
                if (out_free) begin
                  out_nxt       = entry_result(KIND_RESEND, rd_data_r);
                  out_valid_nxt = 1'b1;
                  wr_en         = 1'b1;
                  wr_data       = stamped;
                  idx_nxt       = idx_p1[CW-1:0];
                end else begin
                  // Hold the current entry until the output register frees up.
                  rd_addr = idx_r[AW-1:0];
                end
              end else begin
                idx_nxt = idx_p1[CW-1:0];
              end
            end
          endcase
        end
      end

      S_SHIFT: begin
        // The read data holds entry idx+1, which moves down to idx.
        if (idx_p1 == {1'b0, count_r}) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          idx_nxt = idx_p1[CW-1:0];
          rd_addr = idx_p2[AW-1:0];
        end
      end

      S_FIN: begin
        rd_addr = '0;
        if (out_free) begin
          out_nxt       = fin_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      auth_r      <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      auth_r      <= auth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    fin_r  <= fin_nxt;
    out_r  <= out_nxt;
  end

  // Entry memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= entry_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: src/art_checker.sv
// Port checker for the acknowledgement retransmission table, with its bind.
`default_nettype none

`include "ack_retransmit_table_macros.svh"

module art_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input art_pkg::out_item_t out_data
);
  import art_pkg::*;

  // A stalled result transfer keeps its payload.
  `ART_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // A resend result is never marked last.
  `ART_ASSERT(a_resend_not_last, out_valid && out_data.kind == KIND_RESEND |-> !out_data.last, "resend marked last")

  // Every other kind is the only or final result of its item.
  `ART_ASSERT(a_other_last, out_valid && out_data.kind != KIND_RESEND |-> out_data.last, "final result not marked last")

  // Results that name no entry carry zero fields.
  `ART_ASSERT(a_zero_fields, out_valid && out_data.kind != KIND_RESEND && out_data.kind != KIND_CONFIRMED |-> out_data.plugin_out == 8'd0 && out_data.command_out == 8'd0 && out_data.business_out == 32'd0 && out_data.payload_out == 16'd0, "entry fields not zero")

endmodule

bind ack_retransmit_table art_checker u_art_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: bench/tb_ack_retransmit_table.sv
// Self-checking testbench for the acknowledgement retransmission table.
`timescale 1ns / 1ps

module tb_ack_retransmit_table;
  import art_pkg::*;

  localparam int TABLE_DEPTH = 16;
  // Worst walk plus shift of a full table, with margin.
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int IDLE_PERCENT = 22;
  // Operation codes that the block ignores.
  localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FUNC_RSVD_LAST = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_data = '0;

  // Shadow copy of the table, the authorized flag and the timeout register.
  entry_t shadow_table[TABLE_DEPTH];
  int held_count = 0;
  bit authorized = 1'b0;
  logic [TIMEOUT_W-1:0] timeout_secs = TIMEOUT_RESET;

  // Replies the table owes us, oldest first.
  out_item_t table_replies[$];
  logic [31:0] wall_secs = '0;
  bit steady = 1'b0;
  int failures = 0;
  int transfers_in = 0;
  int results_seen = 0;
  int resends_seen = 0;
  int cycle_count = 0;

  ack_retransmit_table #(.DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped by watchdog after %0d cycles", CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [2:0] f, logic [7:0] plugin,
                                         logic [7:0] command, logic [31:0] business,
                                         logic [31:0] crc, logic [15:0] payload,
                                         logic [31:0] now);
    in_item_t it;
    it.func = f;
    it.plugin = plugin;
    it.command = command;
    it.business_id = business;
    it.crc = crc;
    it.payload_tag = payload;
    it.now_secs = now;
    return it;
  endfunction

  function automatic bit same_key(entry_t e, in_item_t it);
    return e.plugin == it.plugin && e.command == it.command && e.crc == it.crc;
  endfunction

  // Queue one reply; a slot of -1 means the entry fields stay zero.
  function automatic void push_reply(kind_t k, int slot, logic is_last);
    out_item_t r;
    r = '0;
    r.kind = k;
    if (slot >= 0) begin
      r.plugin_out = shadow_table[slot].plugin;
      r.command_out = shadow_table[slot].command;
      r.business_out = shadow_table[slot].business;
      r.payload_out = shadow_table[slot].payload;
    end
    r.last = is_last;
    table_replies = {table_replies, r};
  endfunction

  // Apply one accepted item to the shadow table and queue its replies.
  function automatic void table_apply(in_item_t it);
    int hit;
    logic [31:0] age;
    hit = -1;
    case (it.func)
      FUNC_ADD: begin
        for (int i = 0; i < held_count; i++)
          if (hit < 0 && same_key(shadow_table[i], it)) hit = i;
        if (hit >= 0) begin
          push_reply(KIND_DUP, -1, 1'b1);
        end else if (held_count >= TABLE_DEPTH) begin
          push_reply(KIND_FULL, -1, 1'b1);
        end else begin
          shadow_table[held_count] = '{plugin: it.plugin, command: it.command,
                                       crc: it.crc, business: it.business_id,
                                       payload: it.payload_tag, sent_time: it.now_secs};
          held_count++;
          push_reply(KIND_ADDED, -1, 1'b1);
        end
      end
      FUNC_CONFIRM: begin
        for (int i = 0; i < held_count; i++)
          if (hit < 0 && same_key(shadow_table[i], it) &&
              shadow_table[i].business == it.business_id) hit = i;
        if (hit >= 0) begin
          push_reply(KIND_CONFIRMED, hit, 1'b1);
          // Later entries move down one slot so that order is kept.
          for (int j = hit; j < held_count - 1; j++) shadow_table[j] = shadow_table[j + 1];
          held_count--;
        end else begin
          push_reply(KIND_NOT_FOUND, -1, 1'b1);
        end
      end
      FUNC_TICK: begin
        if (authorized) begin
          for (int i = 0; i < held_count; i++) begin
            // Age wraps modulo 2^32.
            age = it.now_secs - shadow_table[i].sent_time;
            if (age > {16'b0, timeout_secs}) begin
              push_reply(KIND_RESEND, i, 1'b0);
              shadow_table[i].sent_time = it.now_secs;
            end
          end
        end
        push_reply(KIND_DONE, -1, 1'b1);
      end
      FUNC_AUTH: begin
        authorized = 1'b1;
        push_reply(KIND_ACK, -1, 1'b1);
      end
      FUNC_DISC: begin
        authorized = 1'b0;
        push_reply(KIND_ACK, -1, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Send one item, with a random gap in front unless the stream is steady.
  task automatic send_item(in_item_t it);
    if (!steady)
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_apply(it);
    transfers_in++;
  endtask

  // Wait until every reply is in and the block has had time to go idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeout(logic [TIMEOUT_W-1:0] secs);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= secs;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_secs = secs;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Compare every result transfer with the oldest pending reply.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.kind === KIND_RESEND) resends_seen++;
      if (table_replies.size() == 0) begin
        $error("Result of kind %0d arrived with nothing pending", out_data.kind);
        failures++;
      end else begin
        want = table_replies.pop_front();
        check_field("kind", want.kind, out_data.kind);
        check_field("plugin_out", want.plugin_out, out_data.plugin_out);
        check_field("command_out", want.command_out, out_data.command_out);
        check_field("business_out", want.business_out, out_data.business_out);
        check_field("payload_out", want.payload_out, out_data.payload_out);
        check_field("last", want.last, out_data.last);
      end
    end
    out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Tick before authorization, ignored codes, authorize and disconnect.
  task automatic test_control_ops();
    send_item(make_item(FUNC_TICK, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'd1000));
    for (logic [3:0] f = {1'b0, FUNC_RSVD_FIRST}; f <= {1'b0, FUNC_RSVD_LAST}; f++)
      send_item(make_item(f[2:0], 8'($urandom), 8'($urandom), $urandom, $urandom,
                          16'($urandom), $urandom));
    send_item(make_item(FUNC_AUTH, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'h0));
    send_item(make_item(FUNC_DISC, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'h0));
  endtask

  // Field extremes, a duplicate, a near-miss confirm and a confirm mid-table.
  task automatic test_add_confirm();
    send_item(make_item(FUNC_ADD, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'd100));
    send_item(make_item(FUNC_ADD, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                        32'hFFFF_FFF0));
    send_item(make_item(FUNC_ADD, 8'($urandom), 8'($urandom), $urandom, $urandom,
                        16'($urandom), 32'd100));
    send_item(make_item(FUNC_ADD, 8'h00, 8'h00, 32'h1234_5678, 32'h0, 16'h5555, 32'd100));
    send_item(make_item(FUNC_CONFIRM, 8'h00, 8'h00, 32'h1, 32'h0, 16'h0, 32'h0));
    send_item(make_item(FUNC_CONFIRM, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,
                        32'h0));
  endtask

  // Age equal to the timeout, one past it, and an age that wraps past zero.
  task automatic test_expiry();
    set_timeout(16'd10);
    send_item(make_item(FUNC_AUTH, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'h0));
    send_item(make_item(FUNC_TICK, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'd110));
    send_item(make_item(FUNC_TICK, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'd111));
    send_item(make_item(FUNC_ADD, 8'($urandom), 8'($urandom), $urandom, $urandom,
                        16'($urandom), 32'hFFFF_FFFA));
    send_item(make_item(FUNC_TICK, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'd5));
  endtask

  // Fill the table, overflow it, then add a duplicate while it is full.
  task automatic test_full_table();
    int fill;
    fill = TABLE_DEPTH - held_count;
    for (int i = 0; i < fill; i++)
      send_item(make_item(FUNC_ADD, 8'($urandom), 8'($urandom), $urandom, 32'hC0DE_0000 + i,
                          16'($urandom), $urandom));
    send_item(make_item(FUNC_ADD, 8'($urandom), 8'($urandom), $urandom, 32'hBEEF_0001,
                        16'($urandom), $urandom));
    send_item(make_item(FUNC_ADD, 8'h00, 8'h00, $urandom, 32'h0, 16'($urandom), $urandom));
  endtask

  // One random item, mostly adds and confirms; most confirms aim at held entries.
  task automatic random_op(output bit counted);
    in_item_t it;
    int pick;
    int slot;
    it = make_item(FUNC_TICK, 8'($urandom), 8'($urandom), $urandom, $urandom,
                   16'($urandom), wall_secs);
    if ($urandom_range(19) == 0) it.now_secs = $urandom;
    slot = -1;
    if (held_count > 0) slot = $urandom_range(held_count - 1);
    pick = $urandom_range(99);
    counted = 1'b1;
    if (pick < 38) begin
      it.func = FUNC_ADD;
      if (slot >= 0 && $urandom_range(3) == 0) begin
        it.plugin = shadow_table[slot].plugin;
        it.command = shadow_table[slot].command;
        it.crc = shadow_table[slot].crc;
      end
    end else if (pick < 68) begin
      it.func = FUNC_CONFIRM;
      if (slot >= 0 && $urandom_range(9) < 8) begin
        it.plugin = shadow_table[slot].plugin;
        it.command = shadow_table[slot].command;
        it.crc = shadow_table[slot].crc;
        it.business_id = shadow_table[slot].business;
        // Now and then a near miss on the business id.
        if ($urandom_range(7) == 0) it.business_id[$urandom_range(31)] ^= 1'b1;
      end
    end else if (pick < 84) begin
      it.func = FUNC_TICK;
    end else if (pick < 92) begin
      it.func = FUNC_AUTH;
    end else if (pick < 96) begin
      it.func = FUNC_DISC;
    end else begin
      it.func = 3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
      counted = 1'b0;
    end
    send_item(it);
    wall_secs += $urandom_range(0, timeout_secs / 2 + 2);
  endtask

  task automatic run_phase(logic [TIMEOUT_W-1:0] secs, logic [31:0] start, bit no_gaps);
    int sent;
    bit counted;
    set_timeout(secs);
    steady = no_gaps;
    wall_secs = start;
    sent = 0;
    send_item(make_item(FUNC_AUTH, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 32'h0));
    while (sent < ITEMS_PER_PHASE) begin
      random_op(counted);
      if (counted) sent++;
    end
    steady = 1'b0;
  endtask

  // Random traffic under the timeout extremes, the reset value and a random one.
  task automatic test_random_traffic();
    run_phase(16'd0, $urandom, 1'b0);
    run_phase(16'hFFFF, 32'hFFFE_0000, 1'b0);
    run_phase(TIMEOUT_RESET, $urandom, 1'b1);
    run_phase(TIMEOUT_W'($urandom_range(1, 300)), $urandom, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_control_ops();
    test_add_confirm();
    test_expiry();
    test_full_table();
    test_random_traffic();
    settle();
    $display("Covered add, duplicate, full, confirm, near-miss confirm, tick and flag items");
    $display("over four timeout settings: %0d items in, %0d results checked, %0d resends",
             transfers_in, results_seen, resends_seen);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
